[rtl/core/pal_pkg.sv]
// Shared types and codes for the positional array list engine.
package pal_pkg;

    localparam int W_DATA = 32;
    localparam int W_POS  = 7;
    localparam int W_CNT  = 7;

    typedef enum logic [2:0] {
        OP_DISPLAY  = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DELETE   = 3'd2,
        OP_SEARCH   = 3'd3,
        OP_LARGEST  = 3'd4,
        OP_SMALLEST = 3'd5
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DEL,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    // Broadcast to every cell: pos_idx is the 0-based slot, cnt the count before the op.
    typedef struct packed {
        t_cell_op           op;
        logic [W_POS-1:0]   pos_idx;
        logic [W_CNT-1:0]   cnt;
        logic [W_DATA-1:0]  value;
    } t_cell_cmd;

endpackage

[rtl/core/pal_if.sv]
// Request and response channel interfaces of the positional array list engine.
interface pal_req_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          opcode;
    logic [pal_pkg::W_POS-1:0]           position;
    logic signed [pal_pkg::W_DATA-1:0]   operand_value;

    modport source (output valid, output opcode, output position, output operand_value,
                    input ready);
    modport sink   (input valid, input opcode, input position, input operand_value,
                    output ready);
endinterface

interface pal_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic signed [pal_pkg::W_DATA-1:0]   data_out;
    logic [pal_pkg::W_POS-1:0]           found_position;
    logic [pal_pkg::W_CNT-1:0]           entry_count;
    logic                                last;

    modport source (output valid, output status, output data_out, output found_position,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input data_out, input found_position,
                    input entry_count, input last, output ready);
endinterface

[rtl/core/positional_array_list_engine.sv]
// Each defined opcode gives one response word, but display streams count words (one word
// when the list is empty), one per cycle while the response side is ready; spare opcodes
// give none. Search, largest and smallest scan the list first; delete scans, then shifts.
// One request is in flight at a time, and a response stall holds the block until taken.
// Reset (synchronous, active low) empties the list and drops any pending response word.
module positional_array_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pal_req_if.sink   i_req,
    pal_rsp_if.source o_rsp
);

    localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = pal_pkg::W_DATA;
    localparam int PW = pal_pkg::W_POS;
    localparam int CW = pal_pkg::W_CNT;

    pal_pkg::t_state   r_state, n_state;
    pal_pkg::t_opcode  r_op;
    logic [PW-1:0]     r_pos;
    logic [DW-1:0]     r_val;
    logic [CW-1:0]     r_cnt;
    logic [KW-1:0]     r_k;
    logic              r_hit;
    logic [PW-1:0]     r_fpos;
    logic [DW-1:0]     r_best;

    pal_pkg::t_status  r_res_status;
    logic [DW-1:0]     r_res_data;
    logic [PW-1:0]     r_res_fpos;

    logic              r_o_valid;
    pal_pkg::t_status  r_o_status;
    logic [DW-1:0]     r_o_data;
    logic [PW-1:0]     r_o_fpos;
    logic [CW-1:0]     r_o_cnt;
    logic              r_o_last;

    pal_pkg::t_cell_cmd w_cmd;
    logic [DW-1:0]      w_cell [DEPTH];
    logic [DW-1:0]      w_head;

    logic              w_req_fire;
    logic              w_out_free;
    logic              w_step;
    logic              w_k_last;
    logic [PW-1:0]     w_k_pos;
    logic              w_ins_ok;
    logic              w_del_ok;
    logic              w_match;
    logic              n_hit;
    logic [PW-1:0]     n_fpos;
    logic [DW-1:0]     n_best;
    logic              w_set_res;
    pal_pkg::t_status  w_res_status;
    logic [DW-1:0]     w_res_data;
    logic [PW-1:0]     w_res_fpos;
    logic              w_out_load;
    pal_pkg::t_status  w_out_status;
    logic [DW-1:0]     w_out_data;
    logic [PW-1:0]     w_out_fpos;
    logic              w_out_last;

    // ---------------- cell row ----------------
    assign w_head = w_cell[0];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DW-1:0] w_left;
        logic [DW-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        pal_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_head),
            .o_value (w_cell[g])
        );
    end

    // ---------------- common decode ----------------
    assign w_req_fire = i_req.valid && i_req.ready;
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign w_k_last   = (CW'(r_k) == (r_cnt - CW'(1)));
    assign w_k_pos    = PW'(r_k) + PW'(1);
    assign w_ins_ok   = (r_cnt < CW'(DEPTH)) && (r_pos != '0)
                        && ({1'b0, r_pos} <= ({1'b0, r_cnt} + 8'd1));
    assign w_del_ok   = (r_cnt != '0) && (r_pos != '0) && (r_pos <= r_cnt);
    assign w_match    = (w_head == r_val);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pal_pkg::S_IDLE: begin
                if (w_req_fire) begin
                    n_state = pal_pkg::S_DECODE;
                end
            end
            pal_pkg::S_DECODE: begin
                unique case (r_op)
                    pal_pkg::OP_DISPLAY,
                    pal_pkg::OP_SEARCH,
                    pal_pkg::OP_LARGEST,
                    pal_pkg::OP_SMALLEST: begin
                        n_state = (r_cnt == '0) ? pal_pkg::S_EMIT : pal_pkg::S_SCAN;
                    end
                    pal_pkg::OP_INSERT: begin
                        n_state = pal_pkg::S_EMIT;
                    end
                    pal_pkg::OP_DELETE: begin
                        n_state = w_del_ok ? pal_pkg::S_SCAN : pal_pkg::S_EMIT;
                    end
                    default: begin
                        n_state = pal_pkg::S_IDLE;
                    end
                endcase
            end
            pal_pkg::S_SCAN: begin
                if (w_step && w_k_last) begin
                    if (r_op == pal_pkg::OP_DISPLAY) begin
                        n_state = pal_pkg::S_IDLE;
                    end else if (r_op == pal_pkg::OP_DELETE) begin
                        n_state = pal_pkg::S_DEL;
                    end else begin
                        n_state = pal_pkg::S_EMIT;
                    end
                end
            end
            pal_pkg::S_DEL: begin
                n_state = pal_pkg::S_EMIT;
            end
            pal_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = pal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- outputs and datapath control ----------------
    always_comb begin
        i_req.ready  = (r_state == pal_pkg::S_IDLE);
        w_step       = 1'b0;
        w_cmd.op      = pal_pkg::CELL_HOLD;
        w_cmd.pos_idx = r_pos - PW'(1);
        w_cmd.cnt     = r_cnt;
        w_cmd.value   = r_val;

        n_hit  = r_hit | w_match;
        n_fpos = r_hit ? r_fpos : w_k_pos;
        n_best = r_best;
        if (r_k == '0) begin
            n_best = w_head;
        end
        unique case (r_op)
            pal_pkg::OP_LARGEST: begin
                if (r_k == '0 || $signed(w_head) > $signed(r_best)) begin
                    n_best = w_head;
                end
            end
            pal_pkg::OP_SMALLEST: begin
                if (r_k == '0 || $signed(w_head) < $signed(r_best)) begin
                    n_best = w_head;
                end
            end
            pal_pkg::OP_DELETE: begin
                // capture the word at the slot being removed
                n_best = (w_k_pos == r_pos) ? w_head : r_best;
            end
            default: begin
                n_best = r_best;
            end
        endcase

        w_set_res    = 1'b0;
        w_res_status = pal_pkg::ST_OK;
        w_res_data   = '0;
        w_res_fpos   = '0;

        w_out_load   = 1'b0;
        w_out_status = r_res_status;
        w_out_data   = r_res_data;
        w_out_fpos   = r_res_fpos;
        w_out_last   = 1'b1;

        unique case (r_state)
            pal_pkg::S_IDLE: begin
                w_set_res = 1'b0;
            end
            pal_pkg::S_DECODE: begin
                w_set_res = 1'b1;
                unique case (r_op)
                    pal_pkg::OP_INSERT: begin
                        if (r_cnt >= CW'(DEPTH)) begin
                            w_res_status = pal_pkg::ST_FULL;
                        end else if (!w_ins_ok) begin
                            w_res_status = pal_pkg::ST_BADPOS;
                        end else begin
                            w_cmd.op   = pal_pkg::CELL_INS;
                            w_res_data = r_val;
                            w_res_fpos = r_pos;
                        end
                    end
                    pal_pkg::OP_DELETE: begin
                        if (r_cnt == '0) begin
                            w_res_status = pal_pkg::ST_EMPTY;
                        end else if (!w_del_ok) begin
                            w_res_status = pal_pkg::ST_BADPOS;
                        end
                    end
                    pal_pkg::OP_SEARCH: begin
                        w_res_status = pal_pkg::ST_NOTFOUND;
                    end
                    default: begin
                        w_res_status = pal_pkg::ST_EMPTY;
                    end
                endcase
            end
            pal_pkg::S_SCAN: begin
                w_step = (r_op != pal_pkg::OP_DISPLAY) || w_out_free;
                if (w_step) begin
                    w_cmd.op = pal_pkg::CELL_ROT;
                end
                if (r_op == pal_pkg::OP_DISPLAY) begin
                    w_out_load   = w_out_free;
                    w_out_status = pal_pkg::ST_OK;
                    w_out_data   = w_head;
                    w_out_fpos   = w_k_pos;
                    w_out_last   = w_k_last;
                end else if (w_k_last && r_op == pal_pkg::OP_SEARCH) begin
                    w_set_res    = 1'b1;
                    w_res_status = n_hit ? pal_pkg::ST_OK : pal_pkg::ST_NOTFOUND;
                    w_res_data   = n_hit ? r_val : '0;
                    w_res_fpos   = n_hit ? n_fpos : '0;
                end else if (w_k_last && r_op != pal_pkg::OP_DELETE) begin
                    w_set_res    = 1'b1;
                    w_res_data   = n_best;
                end
            end
            pal_pkg::S_DEL: begin
                w_cmd.op   = pal_pkg::CELL_DEL;
                w_set_res  = 1'b1;
                w_res_data = r_best;
                w_res_fpos = r_pos;
            end
            pal_pkg::S_EMIT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_set_res = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pal_pkg::S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pal_pkg::S_DECODE && r_op == pal_pkg::OP_INSERT && w_ins_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_state == pal_pkg::S_DEL) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_op  <= pal_pkg::t_opcode'(i_req.opcode);
            r_pos <= i_req.position;
            r_val <= i_req.operand_value;
        end
        if (r_state == pal_pkg::S_DECODE) begin
            r_k   <= '0;
            r_hit <= 1'b0;
            r_fpos <= '0;
        end else if (w_step) begin
            r_k    <= r_k + KW'(1);
            r_hit  <= n_hit;
            r_fpos <= n_fpos;
            r_best <= n_best;
        end
        if (w_set_res) begin
            r_res_status <= w_res_status;
            r_res_data   <= w_res_data;
            r_res_fpos   <= w_res_fpos;
        end
        if (w_out_load) begin
            r_o_status <= w_out_status;
            r_o_data   <= w_out_data;
            r_o_fpos   <= w_out_fpos;
            r_o_cnt    <= r_cnt;
            r_o_last   <= w_out_last;
        end
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.data_out       = r_o_data;
    assign o_rsp.found_position = r_o_fpos;
    assign o_rsp.entry_count    = r_o_cnt;
    assign o_rsp.last           = r_o_last;

endmodule

[rtl/core/pal_cell.sv]
// One list slot: holds an entry and takes it from a neighbor, the head or the operand.
module pal_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  pal_pkg::t_cell_cmd            i_cmd,
    input  logic [pal_pkg::W_DATA-1:0]    i_left,
    input  logic [pal_pkg::W_DATA-1:0]    i_right,
    input  logic [pal_pkg::W_DATA-1:0]    i_head,
    output logic [pal_pkg::W_DATA-1:0]    o_value
);

    localparam logic [7:0] L_IDX  = 8'(IDX);
    localparam logic [7:0] L_NEXT = 8'(IDX + 1);

    logic [pal_pkg::W_DATA-1:0] r_value;
    logic [pal_pkg::W_DATA-1:0] n_value;
    logic [7:0]                 w_cnt;
    logic [7:0]                 w_pos;

    assign w_cnt = {1'b0, i_cmd.cnt};
    assign w_pos = {1'b0, i_cmd.pos_idx};

    always_comb begin
        n_value = r_value;
        unique case (i_cmd.op)
            pal_pkg::CELL_HOLD: begin
                n_value = r_value;
            end
            pal_pkg::CELL_ROT: begin
                // rotate the live part left; the head wraps to the tail
                if (L_NEXT < w_cnt) begin
                    n_value = i_right;
                end else if (L_NEXT == w_cnt) begin
                    n_value = i_head;
                end
            end
            pal_pkg::CELL_INS: begin
                if (L_IDX == w_pos) begin
                    n_value = i_cmd.value;
                end else if (L_IDX > w_pos && L_IDX <= w_cnt) begin
                    n_value = i_left;
                end
            end
            pal_pkg::CELL_DEL: begin
                if (L_IDX >= w_pos && L_NEXT < w_cnt) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[verif/pal_list_checker.sv]
// List engine checker: predicts every response word from the accepted requests and compares.
`timescale 1ns / 1ps
module pal_list_checker #(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pal_req_if   i_req,
    pal_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        pal_pkg::t_status           status;
        logic [pal_pkg::W_DATA-1:0] data;
        logic [pal_pkg::W_POS-1:0]  pos;
        logic [pal_pkg::W_CNT-1:0]  cnt;
        logic                       last;
    } t_list_word;

    logic signed [pal_pkg::W_DATA-1:0] list_mem [DEPTH];
    int                                list_len;
    t_list_word                        expected_words [$];

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] list check: %s", $time, msg);
    endtask

    function automatic void push_word(pal_pkg::t_status st, logic [pal_pkg::W_DATA-1:0] data,
                                      int pos, bit last);
        t_list_word w;
        w.status = st;
        w.data   = data;
        w.pos    = pal_pkg::W_POS'(pos);
        w.cnt    = pal_pkg::W_CNT'(list_len);
        w.last   = last;
        expected_words.push_back(w);
    endfunction

    function automatic void apply_request(logic [2:0] op, logic [pal_pkg::W_POS-1:0] pos_in,
                                          logic signed [pal_pkg::W_DATA-1:0] val);
        int                                pos;
        int                                hit;
        logic signed [pal_pkg::W_DATA-1:0] best;
        logic signed [pal_pkg::W_DATA-1:0] gone;
        pos = int'(pos_in);
        case (op)
            pal_pkg::OP_DISPLAY: begin
                if (list_len == 0) begin
                    push_word(pal_pkg::ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        push_word(pal_pkg::ST_OK, list_mem[i], i + 1, i + 1 == list_len);
                end
            end
            pal_pkg::OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    push_word(pal_pkg::ST_FULL, '0, 0, 1'b1);
                end else if (pos < 1 || pos > list_len + 1) begin
                    push_word(pal_pkg::ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    for (int i = list_len; i >= pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos-1] = val;
                    list_len++;
                    push_word(pal_pkg::ST_OK, val, pos, 1'b1);
                end
            end
            pal_pkg::OP_DELETE: begin
                if (list_len == 0) begin
                    push_word(pal_pkg::ST_EMPTY, '0, 0, 1'b1);
                end else if (pos < 1 || pos > list_len) begin
                    push_word(pal_pkg::ST_BADPOS, '0, 0, 1'b1);
                end else begin
                    gone = list_mem[pos-1];
                    for (int i = pos - 1; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                    push_word(pal_pkg::ST_OK, gone, pos, 1'b1);
                end
            end
            pal_pkg::OP_SEARCH: begin
                hit = 0;
                for (int i = 0; i < list_len && hit == 0; i++)
                    if (list_mem[i] == val)
                        hit = i + 1;
                if (hit != 0)
                    push_word(pal_pkg::ST_OK, val, hit, 1'b1);
                else
                    push_word(pal_pkg::ST_NOTFOUND, '0, 0, 1'b1);
            end
            pal_pkg::OP_LARGEST, pal_pkg::OP_SMALLEST: begin
                if (list_len == 0) begin
                    push_word(pal_pkg::ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    best = list_mem[0];
                    for (int i = 1; i < list_len; i++)
                        if ((op == pal_pkg::OP_LARGEST) ? (list_mem[i] > best)
                                                        : (list_mem[i] < best))
                            best = list_mem[i];
                    push_word(pal_pkg::ST_OK, best, 0, 1'b1);
                end
            end
            default: ;  // spare opcodes: drop silently
        endcase
    endfunction

    task automatic check_word();
        t_list_word e;
        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d data=%0d pos=%0d cnt=%0d",
                i_rsp.status, i_rsp.data_out, i_rsp.found_position, i_rsp.entry_count));
        end else begin
            e = expected_words.pop_front();
            if (i_rsp.status !== e.status)
                report_mismatch($sformatf("status %0d, want %0d", i_rsp.status, e.status));
            if (i_rsp.data_out !== e.data)
                report_mismatch($sformatf("data_out %0d, want %0d",
                    i_rsp.data_out, $signed(e.data)));
            if (i_rsp.found_position !== e.pos)
                report_mismatch($sformatf("found_position %0d, want %0d",
                    i_rsp.found_position, e.pos));
            if (i_rsp.entry_count !== e.cnt)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                    i_rsp.entry_count, e.cnt));
            if (i_rsp.last !== e.last)
                report_mismatch($sformatf("last %0b, want %0b", i_rsp.last, e.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            list_len = 0;
        end else begin
            // one request in flight: a word seen at this edge belongs to an earlier request
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1)
                check_word();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                apply_request(i_req.opcode, i_req.position, i_req.operand_value);
        end
        o_pending = expected_words.size();
    end

endmodule

[verif/tb_positional_array_list_engine.sv]
// Testbench top for the list engine: drives request words, drains responses, gives the verdict.
`timescale 1ns / 1ps
module tb_positional_array_list_engine;

    localparam int         DEPTH       = 64;
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   calm;
    int   list_len;     // shadow count, to aim positions and end the fill and drain loops

    pal_req_if req ();
    pal_rsp_if rsp ();

    positional_array_list_engine #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    pal_list_checker #(.DEPTH(DEPTH)) u_list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [pal_pkg::W_DATA-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // Response side: random stalls on ready.
    initial begin
        int n;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
            n = calm ? 0 : idle_len();
            if (n > 0) begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Call at a rising edge; returns at the edge that accepted the word with valid still high.
    task automatic send_word(input logic [2:0] op, input logic [pal_pkg::W_POS-1:0] pos,
                             input logic [pal_pkg::W_DATA-1:0] val);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid         <= 1'b1;
        req.opcode        <= op;
        req.position      <= pos;
        req.operand_value <= val;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        if (op == pal_pkg::OP_INSERT && list_len < DEPTH && pos >= 1 && pos <= list_len + 1)
            list_len++;
        else if (op == pal_pkg::OP_DELETE && pos >= 1 && pos <= list_len)
            list_len--;
    endtask

    task automatic random_item(input int ins_pct, input int del_pct);
        int                         r;
        logic [2:0]                 op;
        logic [pal_pkg::W_POS-1:0]  pos;
        r   = $urandom_range(0, 99);
        pos = pal_pkg::W_POS'($urandom_range(1, list_len + 1));
        if (r >= 92) begin
            // noise: any opcode, any position
            op  = 3'($urandom_range(0, 7));
            pos = pal_pkg::W_POS'($urandom_range(0, 127));
        end else if (r < ins_pct) begin
            op = pal_pkg::OP_INSERT;
        end else if (r < ins_pct + del_pct) begin
            op = pal_pkg::OP_DELETE;
            if (list_len > 0)
                pos = pal_pkg::W_POS'($urandom_range(1, list_len));
        end else begin
            case ($urandom_range(0, 3))
                0:       op = pal_pkg::OP_DISPLAY;
                1:       op = pal_pkg::OP_SEARCH;
                2:       op = pal_pkg::OP_LARGEST;
                default: op = pal_pkg::OP_SMALLEST;
            endcase
        end
        send_word(op, pos, pick_value());
    endtask

    initial begin
        int n;
        calm              = 1'b0;
        list_len          = 0;
        i_rst_n           <= 1'b0;
        req.valid         <= 1'b0;
        req.opcode        <= pal_pkg::OP_DISPLAY;
        req.position      <= '0;
        req.operand_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        send_word(pal_pkg::OP_DISPLAY,  7'd0, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd1, 32'h0);
        send_word(pal_pkg::OP_LARGEST,  7'd0, 32'h0);
        send_word(pal_pkg::OP_SMALLEST, 7'd0, 32'h0);
        send_word(pal_pkg::OP_SEARCH,   7'd0, 32'h0);
        send_word(pal_pkg::OP_INSERT,   7'd0, 32'd5);
        send_word(pal_pkg::OP_INSERT,   7'd2, 32'd5);
        // build head, middle and tail inserts with the value extremes
        send_word(pal_pkg::OP_INSERT,   7'd1, 32'h7FFF_FFFF);
        send_word(pal_pkg::OP_INSERT,   7'd1, 32'h8000_0000);
        send_word(pal_pkg::OP_INSERT,   7'd3, 32'h0);
        send_word(pal_pkg::OP_INSERT,   7'd2, 32'hFFFF_FFFF);
        send_word(pal_pkg::OP_INSERT,   7'd127, 32'd9);
        send_word(pal_pkg::OP_INSERT,   7'd5, 32'd1);
        send_word(pal_pkg::OP_DISPLAY,  7'd0, 32'h0);
        send_word(pal_pkg::OP_SEARCH,   7'd0, 32'hFFFF_FFFF);
        send_word(pal_pkg::OP_SEARCH,   7'd0, 32'h1234_5678);
        send_word(pal_pkg::OP_LARGEST,  7'd0, 32'h0);
        send_word(pal_pkg::OP_SMALLEST, 7'd0, 32'h0);
        send_word(OP_SPARE_LO,          7'h7F, 32'hFFFF_FFFF);
        send_word(OP_SPARE_HI,          7'h00, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd0, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd6, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd5, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd1, 32'h0);
        send_word(pal_pkg::OP_DELETE,   7'd127, 32'h0);

        // back-to-back stretch, mixed traffic
        calm = 1'b1;
        repeat (20) random_item(40, 20);
        calm = 1'b0;

        // fill to the top, then hit the full store
        n = 0;
        while (list_len < DEPTH && n < 150) begin
            random_item(90, 3);
            n++;
        end
        send_word(pal_pkg::OP_INSERT,   7'd1, pick_value());
        send_word(pal_pkg::OP_INSERT,   7'd65, pick_value());
        send_word(pal_pkg::OP_DISPLAY,  7'd0, 32'h0);
        send_word(pal_pkg::OP_LARGEST,  7'd0, 32'h0);
        send_word(pal_pkg::OP_SMALLEST, 7'd0, 32'h0);
        send_word(pal_pkg::OP_SEARCH,   7'd0, pick_value());

        repeat (10) random_item(35, 35);

        // drain to empty
        n = 0;
        while (list_len > 0 && n < 150) begin
            random_item(3, 90);
            n++;
        end
        send_word(pal_pkg::OP_DELETE,  7'd1, 32'h0);
        send_word(pal_pkg::OP_DISPLAY, 7'd0, 32'h0);

        repeat (10) random_item(45, 30);

        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // hold so a stray extra word still shows up as a mismatch
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/pal_pkg.sv
rtl/core/pal_if.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list_engine.sv
verif/pal_list_checker.sv
verif/tb_positional_array_list_engine.sv
